FILE: rtl/core/vsk_pkg.sv
// Package for the four-bone vertex skinning core: sizes, opcodes and the
// bone-index wrap table. No dependencies.
package vsk_pkg;

  localparam int MAX_BONES = 64;
  localparam int FRAC_BITS = 16;

  localparam int NUM_INF   = 4;
  localparam int NUM_ROW   = 3;
  localparam int NUM_COL   = 4;
  localparam int NUM_ELEM  = NUM_ROW * NUM_COL;
  localparam int NUM_VEC   = 3;

  localparam int BONE_AW   = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int IDX_W     = 6;
  localparam int IDX_N     = 1 << IDX_W;
  localparam int ELEM_W    = 4;
  localparam int VAL_W     = 32;
  localparam int WGT_W     = 16;
  localparam int OP_W      = 2;

  localparam int PROD_W    = 2 * VAL_W;
  localparam int T_W       = PROD_W + 2;
  localparam int LO_W      = 33;
  localparam int HI_W      = T_W - LO_W;
  localparam int LOP_W     = LO_W + WGT_W;
  localparam int HIP_W     = HI_W + WGT_W + 1;
  localparam int TERM_W    = T_W + WGT_W;
  localparam int ACC_W     = TERM_W + 2;
  localparam int SHIFT_OUT = FRAC_BITS + 15;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_DIR   = 2'd2
  } opcode_t;

  typedef logic [BONE_AW-1:0] bone_addr_t;
  typedef bone_addr_t wrap_tbl_t [IDX_N];

  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t t;
    for (int i = 0; i < IDX_N; i++) begin
      t[i] = BONE_AW'(i % MAX_BONES);
    end
    return t;
  endfunction

  localparam wrap_tbl_t WRAP_TBL = build_wrap();

endpackage

FILE: rtl/core/vsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/vertex_skinning_four_bone_core.sv
// Four-bone linear blend skinning core: bone palette in RAM banks, product,
// weighting, summing and rounding pipeline.
// Depends on vsk_pkg and vsk_ram.
// Skin items pass stage registers 1 to 8 and the output register to out_valid.
// Throughput: one item per cycle while out_ready does not stall the pipeline;
// each influence/element has its own RAM bank, so all 48 matrix words are read together. Loads give no result.
// Reset clears all stage valid bits; the bone palette is not cleared.
module vertex_skinning_four_bone_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [vsk_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [vsk_pkg::VAL_W-1:0]    in_vec_x,
  input  logic signed [vsk_pkg::VAL_W-1:0]    in_vec_y,
  input  logic signed [vsk_pkg::VAL_W-1:0]    in_vec_z,
  input  logic [vsk_pkg::NUM_INF*vsk_pkg::IDX_W-1:0] in_bone_indices,
  input  logic [vsk_pkg::NUM_INF*vsk_pkg::WGT_W-1:0] in_blend_weights,
  input  logic [vsk_pkg::IDX_W-1:0]           in_load_bone,
  input  logic [vsk_pkg::ELEM_W-1:0]          in_load_element,
  input  logic signed [vsk_pkg::VAL_W-1:0]    in_load_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vsk_pkg::VAL_W-1:0]    out_x,
  output logic signed [vsk_pkg::VAL_W-1:0]    out_y,
  output logic signed [vsk_pkg::VAL_W-1:0]    out_z,
  output logic                                out_saturated
);

  import vsk_pkg::*;

  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv_out;
  logic accept_in, load_we, skin_in;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, out_valid_r;

  logic                     pt1_r;
  logic signed [VAL_W-1:0]  vec1_r [NUM_VEC];
  logic [WGT_W-1:0]         w1_r [NUM_INF];
  logic [VAL_W-1:0]         ram_rd [NUM_INF][NUM_ELEM];

  logic signed [PROD_W-1:0] prod2_nxt [NUM_INF][NUM_ROW][NUM_VEC];
  logic signed [PROD_W-1:0] prod2_r   [NUM_INF][NUM_ROW][NUM_VEC];
  logic signed [PROD_W-1:0] tr2_nxt   [NUM_INF][NUM_ROW];
  logic signed [PROD_W-1:0] tr2_r     [NUM_INF][NUM_ROW];
  logic [WGT_W-1:0]         w2_r [NUM_INF];

  logic signed [T_W-1:0]    sa3_nxt [NUM_INF][NUM_ROW];
  logic signed [T_W-1:0]    sb3_nxt [NUM_INF][NUM_ROW];
  logic signed [T_W-1:0]    sa3_r   [NUM_INF][NUM_ROW];
  logic signed [T_W-1:0]    sb3_r   [NUM_INF][NUM_ROW];
  logic [WGT_W-1:0]         w3_r [NUM_INF];

  logic signed [T_W-1:0]    t4_nxt [NUM_INF][NUM_ROW];
  logic signed [T_W-1:0]    t4_r   [NUM_INF][NUM_ROW];
  logic [WGT_W-1:0]         w4_r [NUM_INF];

  logic signed [HIP_W-1:0]  hi5_nxt [NUM_INF][NUM_ROW];
  logic signed [HIP_W-1:0]  hi5_r   [NUM_INF][NUM_ROW];
  logic [LOP_W-1:0]         lo5_nxt [NUM_INF][NUM_ROW];
  logic [LOP_W-1:0]         lo5_r   [NUM_INF][NUM_ROW];

  logic signed [TERM_W-1:0] term6_nxt [NUM_INF][NUM_ROW];
  logic signed [TERM_W-1:0] term6_r   [NUM_INF][NUM_ROW];

  logic signed [ACC_W-1:0]  pair7_nxt [NUM_ROW][2];
  logic signed [ACC_W-1:0]  pair7_r   [NUM_ROW][2];

  logic signed [ACC_W-1:0]  acc8_nxt [NUM_ROW];
  logic signed [ACC_W-1:0]  acc8_r   [NUM_ROW];

  logic signed [ACC_W-1:0]  rnd [NUM_ROW];
  logic [VAL_W-1:0]         res_nxt [NUM_ROW];
  logic [VAL_W-1:0]         res_r   [NUM_ROW];
  logic [NUM_ROW-1:0]       clip;
  logic                     sat_r;

  // handshake chain
  assign adv_out   = !out_valid_r || out_ready;
  assign adv8      = !v8_r || adv_out;
  assign adv7      = !v7_r || adv8;
  assign adv6      = !v6_r || adv7;
  assign adv5      = !v5_r || adv6;
  assign adv4      = !v4_r || adv5;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_ready  = adv1;
  assign accept_in = in_valid && in_ready;

  assign load_we = accept_in && (in_opcode == OP_LOAD) &&
                   (int'(in_load_bone) < MAX_BONES) &&
                   (in_load_element < ELEM_W'(NUM_ELEM));
  assign skin_in = accept_in && ((in_opcode == OP_POINT) || (in_opcode == OP_DIR));

  // palette banks, one per influence and element
  for (genvar k = 0; k < NUM_INF; k++) begin : g_inf
    for (genvar e = 0; e < NUM_ELEM; e++) begin : g_elem
      vsk_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_BONES)
      ) u_bank (
        .clk   (clk),
        .we    (load_we && (in_load_element == ELEM_W'(e))),
        .waddr (BONE_AW'(in_load_bone)),
        .wdata (in_load_value),
        .re    (adv1),
        .raddr (WRAP_TBL[in_bone_indices[k*IDX_W +: IDX_W]]),
        .rdata (ram_rd[k][e])
      );
    end
  end

  // stage 1: side data alongside RAM read
  always_ff @(posedge clk) begin
    if (adv1) begin
      pt1_r     <= (in_opcode == OP_POINT);
      vec1_r[0] <= in_vec_x;
      vec1_r[1] <= in_vec_y;
      vec1_r[2] <= in_vec_z;
      for (int k = 0; k < NUM_INF; k++) begin
        w1_r[k] <= in_blend_weights[k*WGT_W +: WGT_W];
      end
    end
  end

  // stage 2: element products and translation terms (points only)
  always_comb begin
    for (int k = 0; k < NUM_INF; k++) begin
      for (int r = 0; r < NUM_ROW; r++) begin
        for (int c = 0; c < NUM_VEC; c++) begin
          prod2_nxt[k][r][c] = $signed(ram_rd[k][r*NUM_COL+c]) * vec1_r[c];
        end
        tr2_nxt[k][r] = pt1_r ?
            (PROD_W'($signed(ram_rd[k][r*NUM_COL+NUM_VEC])) <<< FRAC_BITS) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      prod2_r <= prod2_nxt;
      tr2_r   <= tr2_nxt;
      w2_r    <= w1_r;
    end
  end

  // stage 3: partial row sums
  always_comb begin
    for (int k = 0; k < NUM_INF; k++) begin
      for (int r = 0; r < NUM_ROW; r++) begin
        sa3_nxt[k][r] = T_W'(prod2_r[k][r][0]) + T_W'(prod2_r[k][r][1]);
        sb3_nxt[k][r] = T_W'(prod2_r[k][r][2]) + T_W'(tr2_r[k][r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      sa3_r <= sa3_nxt;
      sb3_r <= sb3_nxt;
      w3_r  <= w2_r;
    end
  end

  // stage 4: full row sum
  always_comb begin
    for (int k = 0; k < NUM_INF; k++) begin
      for (int r = 0; r < NUM_ROW; r++) begin
        t4_nxt[k][r] = sa3_r[k][r] + sb3_r[k][r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      t4_r <= t4_nxt;
      w4_r <= w3_r;
    end
  end

  // stage 5: weight products, split in high and low halves
  always_comb begin
    for (int k = 0; k < NUM_INF; k++) begin
      for (int r = 0; r < NUM_ROW; r++) begin
        hi5_nxt[k][r] = $signed(t4_r[k][r][T_W-1:LO_W]) * $signed({1'b0, w4_r[k]});
        lo5_nxt[k][r] = t4_r[k][r][LO_W-1:0] * w4_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      hi5_r <= hi5_nxt;
      lo5_r <= lo5_nxt;
    end
  end

  // stage 6: join halves
  always_comb begin
    for (int k = 0; k < NUM_INF; k++) begin
      for (int r = 0; r < NUM_ROW; r++) begin
        term6_nxt[k][r] = (TERM_W'(hi5_r[k][r]) <<< LO_W) +
                          $signed({{(TERM_W-LOP_W){1'b0}}, lo5_r[k][r]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv6) begin
      term6_r <= term6_nxt;
    end
  end

  // stage 7: pair sums
  always_comb begin
    for (int r = 0; r < NUM_ROW; r++) begin
      pair7_nxt[r][0] = ACC_W'(term6_r[0][r]) + ACC_W'(term6_r[1][r]);
      pair7_nxt[r][1] = ACC_W'(term6_r[2][r]) + ACC_W'(term6_r[3][r]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv7) begin
      pair7_r <= pair7_nxt;
    end
  end

  // stage 8: blended sum
  always_comb begin
    for (int r = 0; r < NUM_ROW; r++) begin
      acc8_nxt[r] = pair7_r[r][0] + pair7_r[r][1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv8) begin
      acc8_r <= acc8_nxt;
    end
  end

  // output stage: round half up, shift, saturate
  always_comb begin
    for (int r = 0; r < NUM_ROW; r++) begin
      rnd[r] = acc8_r[r] + (ACC_W'(1) <<< (SHIFT_OUT - 1));
      clip[r] = !((&rnd[r][ACC_W-1:SHIFT_OUT+VAL_W-1]) ||
                  !(|rnd[r][ACC_W-1:SHIFT_OUT+VAL_W-1]));
      if (clip[r]) begin
        res_nxt[r] = rnd[r][ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
        res_nxt[r] = rnd[r][SHIFT_OUT+VAL_W-1:SHIFT_OUT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      res_r <= res_nxt;
      sat_r <= |clip;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1)    v1_r        <= skin_in;
      if (adv2)    v2_r        <= v1_r;
      if (adv3)    v3_r        <= v2_r;
      if (adv4)    v4_r        <= v3_r;
      if (adv5)    v5_r        <= v4_r;
      if (adv6)    v6_r        <= v5_r;
      if (adv7)    v7_r        <= v6_r;
      if (adv8)    v8_r        <= v7_r;
      if (adv_out) out_valid_r <= v8_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = res_r[0];
  assign out_y         = res_r[1];
  assign out_z         = res_r[2];
  assign out_saturated = sat_r;

endmodule

FILE: dv/tb_vertex_skinning_four_bone_core.sv
// Self-checking testbench for vertex_skinning_four_bone_core: loads bone palettes,
// streams point and direction items with random handshake idling and checks results.
// Depends on vsk_pkg and the core RTL.
`timescale 1ns / 1ps

class skin_scoreboard;
  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic [31:0] x, y, z;
    logic        sat;
  } skin_res_t;

  logic [31:0] palette [vsk_pkg::MAX_BONES*vsk_pkg::NUM_ELEM];
  skin_res_t   pending [$];
  int          mismatches;

  function new();
    mismatches = 0;
  endfunction

  function logic [31:0] clip(wide_t a, ref logic sat);
    wide_t s;
    s = (a + (wide_t'(1) <<< (vsk_pkg::SHIFT_OUT - 1))) >>> vsk_pkg::SHIFT_OUT;
    if (s > wide_t'(32'sh7FFFFFFF)) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (s < -wide_t'(64'sh80000000)) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return s[31:0];
  endfunction

  function void note_input(logic [1:0] op, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                           logic [23:0] bi, logic [63:0] bw, logic [5:0] lb,
                           logic [3:0] le, logic [31:0] lv);
    wide_t     acc [3];
    wide_t     v [3];
    wide_t     t, mm, ww;
    int        idx;
    skin_res_t r;
    if (op == vsk_pkg::OP_LOAD) begin
      if (lb < vsk_pkg::MAX_BONES && le < vsk_pkg::NUM_ELEM)
        palette[lb*vsk_pkg::NUM_ELEM + le] = lv;
      return;
    end
    if (op != vsk_pkg::OP_POINT && op != vsk_pkg::OP_DIR) return;
    v[0] = $signed(vx);
    v[1] = $signed(vy);
    v[2] = $signed(vz);
    for (int i = 0; i < 3; i++) acc[i] = '0;
    for (int k = 0; k < vsk_pkg::NUM_INF; k++) begin
      idx = bi[6*k +: 6] % vsk_pkg::MAX_BONES;
      ww = {112'b0, bw[16*k +: 16]};
      for (int rw = 0; rw < 3; rw++) begin
        t = '0;
        for (int c = 0; c < 3; c++) begin
          mm = $signed(palette[idx*12 + rw*4 + c]);
          t = t + mm * v[c];
        end
        if (op == vsk_pkg::OP_POINT) begin
          mm = $signed(palette[idx*12 + rw*4 + 3]);
          t = t + (mm <<< vsk_pkg::FRAC_BITS);
        end
        acc[rw] = acc[rw] + t * ww;
      end
    end
    r.sat = 1'b0;
    r.x = clip(acc[0], r.sat);
    r.y = clip(acc[1], r.sat);
    r.z = clip(acc[2], r.sat);
    pending.push_back(r);
  endfunction

  function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic sat);
    skin_res_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result x=%h y=%h z=%h sat=%b", x, y, z, sat);
      return;
    end
    e = pending.pop_front();
    if (e.x !== x || e.y !== y || e.z !== z || e.sat !== sat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                 e.x, e.y, e.z, e.sat, x, y, z, sat);
    end
  endfunction
endclass

module tb_vertex_skinning_four_bone_core;
  import vsk_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [31:0] in_vec_x, in_vec_y, in_vec_z;
  logic [23:0] in_bone_indices;
  logic [63:0] in_blend_weights;
  logic [5:0]  in_load_bone;
  logic [3:0]  in_load_element;
  logic [31:0] in_load_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_x, out_y, out_z;
  logic        out_saturated;

  skin_scoreboard sb;
  bit      calm;
  int      cycle_cnt = 0;
  bit [11:0] bone_mask [MAX_BONES];
  int      ready_bones [$];

  vertex_skinning_four_bone_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("vertex_skinning_four_bone_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_opcode, in_vec_x, in_vec_y, in_vec_z, in_bone_indices,
                    in_blend_weights, in_load_bone, in_load_element, in_load_value);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_x, out_y, out_z, out_saturated);
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (cycle_cnt == 200) begin
        out_ready = 1'b0;
        for (int i = 0; i < 300; i++) @(negedge clk);
      end
      out_ready = calm || ($urandom_range(99) >= 33);
    end
  end

  task automatic send_item(logic [1:0] op, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                           logic [23:0] bi, logic [63:0] bw, logic [5:0] lb,
                           logic [3:0] le, logic [31:0] lv);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_opcode = op;
    in_vec_x = vx;
    in_vec_y = vy;
    in_vec_z = vz;
    in_bone_indices = bi;
    in_blend_weights = bw;
    in_load_bone = lb;
    in_load_element = le;
    in_load_value = lv;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic load_elem(int bone, int el, logic [31:0] val);
    send_item(OP_LOAD, $urandom, $urandom, $urandom, 24'($urandom), {$urandom, $urandom},
              6'(bone), 4'(el), val);
    if (el < NUM_ELEM) begin
      bone_mask[bone][el] = 1'b1;
      if (bone_mask[bone] == 12'hFFF && !(bone inside {ready_bones})) ready_bones.push_back(bone);
    end
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(65535)) - 32768) <<< $urandom_range(16);
      default: return 32'($signed($urandom_range(131071)) - 65536);
    endcase
  endfunction

  task automatic skin_random();
    logic [23:0] bi;
    logic [63:0] bw;
    logic [1:0]  op;
    for (int k = 0; k < NUM_INF; k++)
      bi[6*k +: 6] = 6'(ready_bones[$urandom_range(ready_bones.size() - 1)]);
    if ($urandom_range(2) == 0) bw = {$urandom, $urandom};
    else for (int k = 0; k < NUM_INF; k++) bw[16*k +: 16] = 16'($urandom_range(16'h3000));
    op = $urandom_range(1) ? OP_POINT : OP_DIR;
    send_item(op, rand_val(), rand_val(), rand_val(), bi, bw, 6'($urandom), 4'($urandom),
              $urandom);
  endtask

  initial begin
    int items;
    int bone;
    int order [12];
    sb = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    in_bone_indices = '0;
    in_blend_weights = '0;
    in_load_bone = '0;
    in_load_element = '0;
    in_load_value = '0;
    for (int b = 0; b < MAX_BONES; b++) bone_mask[b] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int e = 0; e < NUM_ELEM; e++) load_elem(0, e, 32'h80000000);
    for (int e = 0; e < NUM_ELEM; e++) load_elem(MAX_BONES - 1, e, 32'h7FFFFFFF);
    load_elem(0, 15, 32'h12345678);
    send_item(OP_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF,
              64'hFFFFFFFFFFFFFFFF, 6'd0, 4'd0, 32'd0);
    send_item(OP_DIR, 32'h80000000, 32'h80000000, 32'h80000000, 24'h000000,
              64'hFFFFFFFFFFFFFFFF, 6'd0, 4'd0, 32'd0);
    send_item(OP_POINT, 32'h00010000, 32'hFFFF0000, 32'h0, 24'hFC0FC0,
              64'h0, 6'd0, 4'd0, 32'd0);
    send_item(2'd3, 32'h7FFFFFFF, 32'h80000000, 32'h0, 24'hFFFFFF, 64'h8000800080008000,
              6'd0, 4'd0, 32'd0);

    items = 0;
    while (items < 400) begin
      calm = (items >= 150 && items < 230);
      case ($urandom_range(19))
        0, 1, 2: begin
          bone = $urandom_range(MAX_BONES - 1);
          for (int e = 0; e < NUM_ELEM; e++) order[e] = e;
          order.shuffle();
          for (int e = 0; e < NUM_ELEM; e++) load_elem(bone, order[e], rand_val());
          if ($urandom_range(3) == 0) load_elem(bone, $urandom_range(15, 12), $urandom);
          items += NUM_ELEM;
        end
        3: begin
          load_elem($urandom_range(MAX_BONES - 1), $urandom_range(15), rand_val());
          items++;
        end
        4: begin
          send_item(2'd3, $urandom, $urandom, $urandom, 24'($urandom), {$urandom, $urandom},
                    6'($urandom), 4'($urandom), $urandom);
        end
        default: begin
          skin_random();
          items++;
        end
      endcase
    end
    in_valid = 1'b0;
    calm = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("vertex_skinning_four_bone_core verification clean");
    else
      $display("vertex_skinning_four_bone_core verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/vsk_pkg.sv
rtl/core/vsk_ram.sv
rtl/core/vertex_skinning_four_bone_core.sv
dv/tb_vertex_skinning_four_bone_core.sv
